// ===== rtl/core/fewc_pkg.sv =====
// Shared types, constants and the CRC-32 nibble table for the flash record writer.
// Used by every module of the block; depends on nothing else.
package fewc_pkg;

	localparam int MAX_PAGE_BYTES = 8;
	localparam int CRC_BYTES      = 4;
	localparam int MAX_RESULTS    = 4;
	localparam int PAGE_BITS      = 8 * MAX_PAGE_BYTES;

	localparam logic [1:0] PAGE_SIZE_LOG2_RESET = 2'd3;
	localparam logic [7:0] FILL_BYTE_RESET      = 8'hff;

	// Configuration register indexes.
	localparam logic REG_PAGE_SIZE_LOG2 = 1'b0;
	localparam logic REG_FILL_BYTE      = 1'b1;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  data_byte;
		logic [31:0] record_address;
		logic [15:0] record_length;
	} item_t;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page_buffer;
		logic [31:0]          running_crc;
		logic [15:0]          write_offset;
		logic [31:0]          record_base;
		logic [15:0]          record_size;
	} rec_state_t;

	// All results caused by one request: up to four pages, or one empty result.
	typedef struct packed {
		logic [2:0]                             page_count;
		logic                                   status;
		logic [MAX_RESULTS-1:0][31:0]           addr;
		logic [MAX_RESULTS-1:0][PAGE_BITS-1:0]  data;
	} result_set_t;

	// Reflected CRC-32 (0xEDB88320) table for one nibble step.
	function automatic logic [31:0] nib_tab(input logic [3:0] idx);
		logic [31:0] v;
		case (idx)
			4'h0: v = 32'h00000000;
			4'h1: v = 32'h1db71064;
			4'h2: v = 32'h3b6e20c8;
			4'h3: v = 32'h26d930ac;
			4'h4: v = 32'h76dc4190;
			4'h5: v = 32'h6b6b51f4;
			4'h6: v = 32'h4db26158;
			4'h7: v = 32'h5005713c;
			4'h8: v = 32'hedb88320;
			4'h9: v = 32'hf00f9344;
			4'ha: v = 32'hd6d6a3e8;
			4'hb: v = 32'hcb61b38c;
			4'hc: v = 32'h9b64c2b0;
			4'hd: v = 32'h86d3d2d4;
			4'he: v = 32'ha00ae278;
			default: v = 32'hbdbdf21c;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/fewc_crc_byte.sv =====
// One-byte CRC-32 update, inverted in and out, as two nibble table steps.
// Depends on fewc_pkg for the nibble table.
module fewc_crc_byte (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data_byte,
	output logic [31:0] crc_out
);
	import fewc_pkg::*;

	logic [31:0] c0;
	logic [31:0] c1;
	logic [31:0] c2;

	always_comb begin
		c0 = ~crc_in;
		c1 = (c0 >> 4) ^ nib_tab(c0[3:0] ^ data_byte[3:0]);
		c2 = (c1 >> 4) ^ nib_tab(c1[3:0] ^ data_byte[7:4]);
		crc_out = ~c2;
	end

endmodule

// ===== rtl/core/fewc_page_builder.sv =====
// Combinational core: from one registered request and the record state it forms
// every page the request completes and the next record state. Depends on fewc_pkg
// and fewc_crc_byte.
module fewc_page_builder (
	input  fewc_pkg::item_t       item,
	input  fewc_pkg::rec_state_t  cur,
	input  logic [1:0]            page_size_log2,
	input  logic [7:0]            fill_byte,
	output fewc_pkg::result_set_t res,
	output fewc_pkg::rec_state_t  nxt
);
	import fewc_pkg::*;

	logic [31:0]          crc_upd;
	logic [3:0]           psz;
	logic [2:0]           pmask;
	logic [PAGE_BITS-1:0] keep_mask;
	logic [2:0]           slot;
	logic [PAGE_BITS-1:0] buf_ins;
	logic [15:0]          wo1;
	logic                 data_full;
	logic                 size_ok;
	logic [15:0]          sizem4;
	logic                 fin_ok;
	logic [15:0]          start0;
	logic [17:0]          pstart [MAX_RESULTS];
	logic [17:0]          pos;
	logic [1:0]           crc_sel;
	logic [MAX_RESULTS-1:0]        emit;
	logic [MAX_RESULTS-1:0][PAGE_BITS-1:0] fin_data;

	fewc_crc_byte u_crc (
		.crc_in   (cur.running_crc),
		.data_byte(item.data_byte),
		.crc_out  (crc_upd)
	);

	always_comb begin
		psz   = 4'd1 << page_size_log2;
		pmask = 3'(psz - 4'd1);
		for (int s = 0; s < MAX_PAGE_BYTES; s++) begin
			keep_mask[8*s +: 8] = (4'(s) < psz) ? 8'hff : 8'h00;
		end

		// Data byte path.
		slot = cur.write_offset[2:0] & pmask;
		buf_ins = cur.page_buffer;
		buf_ins[{slot, 3'b000} +: 8] = item.data_byte;
		wo1 = cur.write_offset + 16'd1;
		data_full = (wo1[2:0] & pmask) == 3'd0;

		// Finish path: pad and trailer bytes are placed by their offset in the record.
		size_ok = cur.record_size >= 16'(CRC_BYTES);
		sizem4  = cur.record_size - 16'(CRC_BYTES);
		fin_ok  = size_ok && (cur.write_offset <= sizem4) &&
			((sizem4 - cur.write_offset) < {12'd0, psz});
		start0  = cur.write_offset & ~{13'd0, pmask};
		for (int j = 0; j < MAX_RESULTS; j++) begin
			pstart[j] = {2'b00, start0} + 18'(j) * {14'd0, psz};
			emit[j] = (pstart[j] + {14'd0, psz}) <= {2'b00, cur.record_size};
			for (int s = 0; s < MAX_PAGE_BYTES; s++) begin
				pos = pstart[j] + 18'(s);
				crc_sel = pos[1:0] - sizem4[1:0];
				if (pos < {2'b00, cur.write_offset}) begin
					fin_data[j][8*s +: 8] = cur.page_buffer[8*s +: 8];
				end else if (pos < {2'b00, sizem4}) begin
					fin_data[j][8*s +: 8] = fill_byte;
				end else begin
					fin_data[j][8*s +: 8] = cur.running_crc[{crc_sel, 3'b000} +: 8];
				end
			end
			fin_data[j] = fin_data[j] & keep_mask;
		end

		res.page_count = '0;
		res.status     = 1'b0;
		res.addr       = '0;
		res.data       = '0;
		nxt            = cur;

		unique case (item.command)
			CMD_START: begin
				nxt.record_base  = item.record_address;
				nxt.record_size  = item.record_length;
				nxt.write_offset = '0;
				nxt.running_crc  = '0;
				nxt.page_buffer  = '0;
			end
			CMD_DATA: begin
				if (cur.write_offset >= cur.record_size) begin
					res.status = 1'b1;
				end else begin
					nxt.running_crc  = crc_upd;
					nxt.write_offset = wo1;
					if (data_full) begin
						res.page_count = 3'd1;
						res.addr[0] = cur.record_base + {16'd0, wo1} - {28'd0, psz};
						res.data[0] = buf_ins & keep_mask;
						nxt.page_buffer = '0;
					end else begin
						nxt.page_buffer = buf_ins;
					end
				end
			end
			CMD_FINISH: begin
				if (!fin_ok) begin
					res.status = 1'b1;
				end else begin
					res.page_count = 3'($countones(emit));
					for (int j = 0; j < MAX_RESULTS; j++) begin
						if (emit[j]) begin
							res.addr[j] = cur.record_base + {16'd0, pstart[j][15:0]};
							res.data[j] = fin_data[j];
						end
					end
					// The record is closed: only a new start touches the buffer again.
					nxt.write_offset = cur.record_size;
					nxt.page_buffer  = '0;
				end
			end
			CMD_NONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/fewc_result_queue.sv =====
// Result stage: holds the result set of one request and hands it out one result
// per cycle on the master stream while the receiver is ready. Depends on fewc_pkg.
module fewc_result_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  fewc_pkg::result_set_t set_in,
	output logic                  free,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [95:0]           m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);
	import fewc_pkg::*;

	logic        valid_q;
	logic [1:0]  idx_q;
	result_set_t set_q;
	logic [1:0]  last_idx;
	logic        take;

	assign last_idx = (set_q.page_count == 3'd0) ? 2'd0 : 2'(set_q.page_count - 3'd1);
	assign m_tvalid = valid_q;
	assign m_tlast  = idx_q == last_idx;
	assign take     = valid_q && m_tready;
	assign free     = !valid_q || (m_tready && m_tlast);
	assign m_tdata  = {set_q.data[idx_q], set_q.addr[idx_q]};
	assign m_tuser  = {set_q.status, set_q.page_count != 3'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (m_tlast) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			set_q <= set_in;
		end
	end

endmodule

// ===== rtl/core/flash_entry_writer_crc32_page_buffer.sv =====
// Top level of the flash record writer: input register, record state, configuration.
// Depends on fewc_pkg, fewc_page_builder and fewc_result_queue.
//
// Usage. Requests arrive on the slave stream: tuser carries the command (start,
// data byte, finish), tdata the byte, the record address and the record length.
// A start opens a record, each data byte extends its CRC-32 and fills the page
// buffer, and a finish pads with the fill byte and appends the CRC little-endian.
// Results leave on the master stream, one per cycle while the receiver is ready:
// tdata holds the page address and page bytes, tuser says whether a page is
// carried and whether the request was rejected, and tlast marks the final result
// of a request. An accepted request waits in the input register, then passes
// through the page builder into the result stage, which shows its first result.
// Throughput is one request per cycle while each request yields a single result
// and the receiver is ready; a finish that completes k pages (k at most four)
// holds the result stage until all k are taken, since all of them sit in that stage.
// At reset the record state is cleared, the page size is eight bytes and the fill
// byte is 0xff. When the receiver stalls, the result stage holds its result, the
// input register keeps the next request and the slave tready drops. Configuration
// writes go through cfg_we, cfg_index and cfg_data while idle (user's rule, not enforced).
module flash_entry_writer_crc32_page_buffer (
	input  logic        clk,
	input  logic        arst_n,
	// Slave stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // data_byte[7:0], record_address[39:8], record_length[55:40]
	input  logic [1:0]  s_tuser,  // command[1:0]
	// Master stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // program_address[31:0], program_data[95:32]
	output logic [1:0]  m_tuser,  // program_valid[0], status[1]
	output logic        m_tlast,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import fewc_pkg::*;

	logic [1:0]  psz_log2_q;
	logic [7:0]  fill_byte_q;
	logic        valid_s1;
	item_t       item_s1;
	rec_state_t  state_q;
	rec_state_t  state_nxt;
	result_set_t set_nxt;
	logic        res_free;
	logic        advance;

	// The input register may refill in the same cycle its request moves on.
	assign advance  = valid_s1 && res_free;
	assign s_tready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psz_log2_q  <= PAGE_SIZE_LOG2_RESET;
			fill_byte_q <= FILL_BYTE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAGE_SIZE_LOG2: psz_log2_q  <= cfg_data[1:0];
				REG_FILL_BYTE:      fill_byte_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command        <= cmd_t'(s_tuser);
			item_s1.data_byte      <= s_tdata[7:0];
			item_s1.record_address <= s_tdata[39:8];
			item_s1.record_length  <= s_tdata[55:40];
		end
	end

	// Record state moves only when a request passes into the result stage, so the
	// next request in the input register always sees the state this one left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	fewc_page_builder u_builder (
		.item          (item_s1),
		.cur           (state_q),
		.page_size_log2(psz_log2_q),
		.fill_byte     (fill_byte_q),
		.res           (set_nxt),
		.nxt           (state_nxt)
	);

	fewc_result_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.set_in  (set_nxt),
		.free    (res_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// A request that passes the builder always shows up as a result next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed request produced no result");

	// A result without a page is the only result of its request.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("empty result not marked last");

	// A rejected request never carries a page.
	a_reject_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("rejected request carries a page");

	// The input register holds its request while the result stage is busy.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !res_free |=> valid_s1 && $stable(item_s1) && $stable(state_q))
		else $error("request or state changed while result stage busy");

	// The page size changes only after a configuration write.
	a_cfg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg_we) |-> $stable(psz_log2_q))
		else $error("page size changed without a write");

endmodule

// ===== tb/fewc_tb_pkg.sv =====
// Scoreboard for the flash record writer: a cycle-free predictor of the pages
// each request programs, and an in-order check of the results. Depends on fewc_pkg.
package fewc_tb_pkg;

	import fewc_pkg::*;

	localparam logic [31:0] CRC32_POLY = 32'hedb88320;

	typedef struct {
		logic [31:0] address;
		logic [63:0] data;
		logic        valid;
		logic        status;
		logic        last;
	} page_result_t;

	class record_page_scoreboard;
		page_result_t expected_pages[$];
		page_result_t request_pages[$];
		int           error_count = 0;

		logic [1:0]   page_log2 = PAGE_SIZE_LOG2_RESET;
		logic [7:0]   fill      = FILL_BYTE_RESET;
		logic [63:0]  page_buf  = '0;
		logic [31:0]  crc       = '0;
		logic [15:0]  offset    = '0;
		logic [15:0]  size      = '0;
		logic [31:0]  base      = '0;

		function void write_register(input logic index, input logic [7:0] value);
			if (index == REG_PAGE_SIZE_LOG2) begin
				page_log2 = value[1:0];
			end else begin
				fill = value;
			end
		endfunction

		function int unsigned page_bytes();
			return 32'd1 << page_log2;
		endfunction

		// Reflected CRC-32 over one byte, bit at a time; the stored value is post-inverted.
		function logic [31:0] crc32_update(input logic [31:0] crc_in, input logic [7:0] b);
			logic [31:0] c;
			int          i;
			c = ~crc_in ^ {24'd0, b};
			for (i = 0; i < 8; i++) begin
				c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
			end
			return ~c;
		endfunction

		// Put one byte in its page slot and emit the page once the slot wraps.
		function void place_byte(input logic [7:0] b);
			int unsigned  psz;
			int unsigned  slot;
			logic [63:0]  mask;
			page_result_t r;
			psz  = page_bytes();
			slot = offset & (psz - 1);
			page_buf[8*slot +: 8] = b;
			offset = offset + 16'd1;
			if ((offset & (psz - 1)) == 0 && request_pages.size() < MAX_RESULTS) begin
				mask      = (psz >= 8) ? '1 : ((64'd1 << (8 * psz)) - 64'd1);
				r.address = base + 32'(offset) - psz;
				r.data    = page_buf & mask;
				r.valid   = 1'b1;
				r.status  = 1'b0;
				r.last    = 1'b0;
				request_pages.push_back(r);
				page_buf = '0;
			end
		endfunction

		function void accept_request(input cmd_t cmd, input logic [7:0] b,
				input logic [31:0] addr, input logic [15:0] len);
			logic         rejected;
			int unsigned  psz;
			int           i;
			page_result_t r;
			request_pages.delete();
			rejected = 1'b0;
			case (cmd)
				CMD_START: begin
					base     = addr;
					size     = len;
					offset   = '0;
					crc      = '0;
					page_buf = '0;
				end
				CMD_DATA: begin
					if (offset >= size) begin
						rejected = 1'b1;
					end else begin
						crc = crc32_update(crc, b);
						place_byte(b);
					end
				end
				CMD_FINISH: begin
					psz = page_bytes();
					if (size < CRC_BYTES || offset > size - CRC_BYTES ||
							size - CRC_BYTES - offset >= psz) begin
						rejected = 1'b1;
					end else begin
						while (offset < size - CRC_BYTES) begin
							place_byte(fill);
						end
						for (i = 0; i < CRC_BYTES; i++) begin
							place_byte(crc[8*i +: 8]);
						end
					end
				end
				default: ;
			endcase
			if (request_pages.size() == 0) begin
				r.address = '0;
				r.data    = '0;
				r.valid   = 1'b0;
				r.status  = rejected;
				r.last    = 1'b0;
				request_pages.push_back(r);
			end
			r = request_pages.pop_back();
			r.last = 1'b1;
			request_pages.push_back(r);
			foreach (request_pages[k]) begin
				expected_pages.push_back(request_pages[k]);
			end
		endfunction

		function void check_page_result(input logic [31:0] addr, input logic [63:0] data,
				input logic valid, input logic status, input logic last);
			page_result_t e;
			if (expected_pages.size() == 0) begin
				$error("result with nothing outstanding: address %h data %h", addr, data);
				error_count++;
				return;
			end
			e = expected_pages.pop_front();
			if (addr !== e.address) begin
				$error("program_address: expected %h, actual %h", e.address, addr);
				error_count++;
			end
			if (data !== e.data) begin
				$error("program_data: expected %h, actual %h", e.data, data);
				error_count++;
			end
			if (valid !== e.valid) begin
				$error("program_valid: expected %b, actual %b", e.valid, valid);
				error_count++;
			end
			if (status !== e.status) begin
				$error("status: expected %b, actual %b", e.status, status);
				error_count++;
			end
			if (last !== e.last) begin
				$error("last: expected %b, actual %b", e.last, last);
				error_count++;
			end
		endfunction

		function int outstanding();
			return expected_pages.size();
		endfunction
	endclass

endpackage

// ===== tb/tb_flash_entry_writer_crc32_page_buffer.sv =====
// Top-level testbench for the flash record writer: directed and random requests,
// random idling on both streams, results checked by the scoreboard in fewc_tb_pkg.
// Depends on fewc_pkg, fewc_tb_pkg and the block's RTL.
module tb_flash_entry_writer_crc32_page_buffer;
	timeunit 1ns;
	timeprecision 1ps;

	import fewc_pkg::*;
	import fewc_tb_pkg::*;

	// The slowest legal run is a few hundred requests, each with at most four
	// pages, behind a receiver that is ready about a quarter of the time; the
	// limit leaves ample headroom.
	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	record_page_scoreboard sb = new;

	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          requests_sent = 0;
	logic [1:0]  page_log2 = PAGE_SIZE_LOG2_RESET;
	bit          record_open = 1'b0;

	flash_entry_writer_crc32_page_buffer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The receiver drops tready at random; the rate follows the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Inputs only change at rising edges, so the values seen at the falling edge
	// are the ones the next rising edge will sample. Results are checked there.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_page_result(m_tdata[31:0], m_tdata[95:32], m_tuser[0], m_tuser[1],
				m_tlast);
		end
	end

	// Present one request and hold it until the block takes it. tvalid is left
	// high afterwards, so back-to-back requests drop it only for random idling.
	task automatic send_request(input cmd_t cmd, input logic [7:0] b,
			input logic [31:0] addr, input logic [15:0] len);
		bit taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {len, addr, b};
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			if (taken) begin
				sb.accept_request(cmd, b, addr, len);
			end
			@(posedge clk);
		end
		if (cmd != CMD_NONE) begin
			requests_sent++;
		end
	endtask

	// Fields a command ignores still carry random bits so every input bit toggles.
	task automatic send_data(input logic [7:0] b);
		send_request(CMD_DATA, b, $urandom, 16'($urandom));
	endtask

	task automatic send_start(input logic [31:0] addr, input logic [15:0] len);
		send_request(CMD_START, 8'($urandom), addr, len);
	endtask

	task automatic send_finish();
		send_request(CMD_FINISH, 8'($urandom), $urandom, 16'($urandom));
	endtask

	task automatic send_unused();
		send_request(CMD_NONE, 8'($urandom), $urandom, 16'($urandom));
	endtask

	// Stop presenting requests and wait until every result has come back, so the
	// pipeline is empty before a register changes.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic index, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.write_register(index, value);
		if (index == REG_PAGE_SIZE_LOG2) begin
			page_log2 = value[1:0];
		end
	endtask

	// Record payload bytes lean toward all-zeros and all-ones.
	function automatic logic [7:0] record_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// A well-formed record: a start that is mostly aligned, a length that is a
	// whole number of pages, enough bytes that the finish pads less than one
	// page, then the finish. Now and then an unused command slips in, or a
	// request follows the finish that must be turned away.
	task automatic write_record();
		int unsigned psz;
		int unsigned size;
		int unsigned gap;
		int unsigned i;
		logic [31:0] addr;
		psz  = 32'd1 << page_log2;
		size = psz * $urandom_range(1, 3) + ((psz < 4) ? 4 : 0);
		gap  = $urandom_range(0, psz - 1);
		if (gap > size - CRC_BYTES) begin
			gap = size - CRC_BYTES;
		end
		case ($urandom_range(0, 9))
			0: addr = 32'hffff_fff8 & ~(psz - 1);
			1: addr = $urandom;
			default: addr = $urandom & ~(psz - 1);
		endcase
		send_start(addr, 16'(size));
		for (i = 0; i < size - CRC_BYTES - gap; i++) begin
			if ($urandom_range(0, 99) < 5) begin
				send_unused();
			end
			send_data(record_byte());
		end
		send_finish();
		if ($urandom_range(0, 99) < 15) begin
			send_data(record_byte());
		end
		if ($urandom_range(0, 99) < 10) begin
			send_finish();
		end
	endtask

	// Noise: random commands in random order, starts with odd lengths among them.
	task automatic send_noise();
		int   n;
		int   k;
		cmd_t c;
		logic [15:0] len;
		n = $urandom_range(2, 8);
		for (k = 0; k < n; k++) begin
			c = cmd_t'($urandom_range(0, 3));
			case (c)
				CMD_START: begin
					case ($urandom_range(0, 3))
						0: len = 16'd0;
						1: len = 16'hffff;
						2: len = 16'($urandom);
						default: len = 16'($urandom_range(0, 12));
					endcase
					send_start($urandom, len);
				end
				CMD_DATA:   send_data(record_byte());
				CMD_FINISH: send_finish();
				default:    send_unused();
			endcase
		end
	endtask

	initial begin
		int blk;
		int target;
		int i;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at reset settings: eight-byte pages, fill byte 0xff.
		// With no record open, a data byte and a finish are both rejected, and an
		// unused command gives one empty result.
		send_data(8'h5a);
		send_finish();
		send_unused();

		// Record near the top of the address space: the second page address
		// wraps to zero. Payload bytes cover both extremes.
		send_start(32'hffff_fff8, 16'd16);
		send_data(8'h00);
		send_data(8'hff);
		send_data(8'h01);
		send_data(8'h80);
		send_data(8'h7f);
		send_data(8'hfe);
		send_data(8'h55);
		send_data(8'haa);
		send_data(8'h3c);
		send_data(8'hc3);
		send_finish();
		// After a good finish the record is full: both of these are rejected.
		send_data(8'h99);
		send_finish();

		// Maximum length at the highest address: the pad gap is far more than a
		// page, so the finish is rejected.
		send_start(32'hffff_ffff, 16'hffff);
		send_finish();

		// Page size changed inside an open record: one-byte pages make the
		// finish emit four pages, one per CRC byte.
		send_start(32'h0000_1000, 16'd8);
		send_data(8'h31);
		send_data(8'h32);
		send_data(8'h33);
		send_data(8'h34);
		quiesce();
		write_register(REG_PAGE_SIZE_LOG2, 8'd0);
		write_register(REG_FILL_BYTE, 8'h00);
		send_finish();

		// A record shorter than its own CRC can never be finished.
		send_start(32'h0000_2000, 16'd3);
		send_finish();

		// Random part in three phases of four blocks: sender mostly busy and
		// receiver mostly stalled, then the reverse, then no idling at all.
		// Registers change between blocks once the block is drained.
		requests_sent = 0;
		for (blk = 0; blk < 12; blk++) begin
			quiesce();
			case (blk / 4)
				0: begin
					send_idle_pct = 6;
					recv_idle_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 6;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// Upper data bits of the page size write are don't-care; make them random.
			write_register(REG_PAGE_SIZE_LOG2,
				{6'($urandom), (blk < 4) ? 2'(blk) : 2'($urandom_range(0, 3))});
			case (blk % 3)
				0: write_register(REG_FILL_BYTE, 8'h00);
				1: write_register(REG_FILL_BYTE, 8'hff);
				default: write_register(REG_FILL_BYTE, 8'($urandom));
			endcase

			// A record left open by the previous block is finished under the new
			// page size; it succeeds only when the remaining gap fits in a page.
			if (record_open) begin
				send_finish();
				record_open = 1'b0;
			end

			target = requests_sent + 12;
			while (requests_sent < target) begin
				if ($urandom_range(0, 99) < 75) begin
					write_record();
				end else begin
					send_noise();
				end
			end

			if ($urandom_range(0, 1) == 1) begin
				send_start($urandom & 32'hffff_fff8, 16'd16);
				for (i = $urandom_range(9, 12); i > 0; i--) begin
					send_data(record_byte());
				end
				record_open = 1'b1;
			end
		end

		quiesce();
		repeat (8) @(posedge clk);
		if (sb.error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
